@@ src/lfu_pkg.sv @@
// shared types and constants for the lfu cache table
// used by lfu_pick and lfu_cache_table, no dependencies
package lfu_pkg;

    localparam int KEY_BITS = 32;
    localparam int CAP_BITS = 5;
    localparam int CAP_RESET = 16;
    localparam int NEW_COUNT = 1;
    localparam logic signed [KEY_BITS-1:0] MISS_VALUE = -32'sd1;
    localparam logic signed [KEY_BITS-1:0] NO_KEY = 32'sd0;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_PROMO  = 4'b1000
    } t_state;

    typedef struct packed {
        logic take_match;
        logic take_free;
        logic take_victim;
    } t_pick;

endpackage

@@ src/lfu_pick.sv @@
// per-entry compare unit shared across the table scan
// depends on lfu_pkg for t_pick and KEY_BITS
module lfu_pick #(
    parameter int COUNT_BITS = 16,
    parameter int RANK_BITS  = 4
) (
    input  logic                          i_valid,
    input  logic [lfu_pkg::KEY_BITS-1:0]  i_key,
    input  logic [lfu_pkg::KEY_BITS-1:0]  i_ref_key,
    input  logic [COUNT_BITS-1:0]         i_cnt,
    input  logic [RANK_BITS-1:0]          i_rank,
    input  logic                          i_have_match,
    input  logic                          i_have_free,
    input  logic                          i_have_victim,
    input  logic [COUNT_BITS-1:0]         i_best_cnt,
    input  logic [RANK_BITS-1:0]          i_best_rank,
    output lfu_pkg::t_pick                o_pick
);
    import lfu_pkg::*;

    logic w_older;

    assign w_older = (i_cnt < i_best_cnt) ||
                     ((i_cnt == i_best_cnt) && (i_rank > i_best_rank));

    always_comb begin
        o_pick.take_match  = i_valid && !i_have_match && (i_key == i_ref_key);
        o_pick.take_free   = !i_valid && !i_have_free;
        o_pick.take_victim = i_valid && (!i_have_victim || w_older);
    end

endmodule

@@ src/lfu_cache_table.sv @@
// lfu cache table with lru tie-break: scan sequencer, entry memories, outputs
// depends on lfu_pkg and lfu_pick
//
// channel   direction  signals                                       handshake
// request   in         i_mode i_key i_value                          start & !busy
// result    out        o_hit o_read_value o_evicted o_evicted_key    o_done pulse
// config    in         i_cfg_wdata                                   i_cfg_we
//
// a request scans all entries once through one compare unit, decides in S_DECIDE,
// then sweeps the recency-rank memory over all entries when an entry is touched;
// o_done is registered at the end of the sweep, or after the decision otherwise.
// the rank memory is read, modified and written back one entry at a time.
// synchronous active-low reset clears valid bits and occupancy and sets capacity to 16.
// o_done is high one cycle; the receiver cannot stall, busy holds off requests.
module lfu_cache_table #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_mode,
    input  logic signed [lfu_pkg::KEY_BITS-1:0]  i_key,
    input  logic signed [lfu_pkg::KEY_BITS-1:0]  i_value,
    output logic                                 o_done,
    output logic                                 o_hit,
    output logic signed [lfu_pkg::KEY_BITS-1:0]  o_read_value,
    output logic                                 o_evicted,
    output logic signed [lfu_pkg::KEY_BITS-1:0]  o_evicted_key,
    input  logic                                 i_cfg_we,
    input  logic [lfu_pkg::CAP_BITS-1:0]         i_cfg_wdata
);
    import lfu_pkg::*;

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW   = IW;
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (OW > CAP_BITS) ? OW : CAP_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    t_state r_state, n_state;

    logic [CAP_BITS-1:0]  r_cap;
    logic [OW-1:0]        r_occ;
    logic [ENTRIES-1:0]   r_valid;

    logic                 r_mode;
    logic [KEY_BITS-1:0]  r_key;
    logic [KEY_BITS-1:0]  r_value;

    logic [IW-1:0]        r_idx;
    logic                 r_issue;
    logic                 r_rdv;
    logic [IW-1:0]        r_rdidx;

    logic [KEY_BITS-1:0]   mem_key  [ENTRIES];
    logic [KEY_BITS-1:0]   mem_val  [ENTRIES];
    logic [COUNT_BITS-1:0] mem_cnt  [ENTRIES];
    logic [RW-1:0]         mem_rank [ENTRIES];

    logic [KEY_BITS-1:0]   r_rd_key;
    logic [KEY_BITS-1:0]   r_rd_val;
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic [RW-1:0]         r_rd_rank;

    logic                  r_have_match, r_have_free, r_have_vic;
    logic [IW-1:0]         r_m_idx, r_f_idx, r_v_idx;
    logic [COUNT_BITS-1:0] r_m_cnt, r_v_cnt;
    logic [RW-1:0]         r_m_rank, r_v_rank;
    logic [KEY_BITS-1:0]   r_m_val, r_v_key;

    logic [IW-1:0]         r_tgt;
    logic [RW-1:0]         r_lim;
    logic                  r_lim_all;

    logic                  r_done, r_hit, r_evicted;
    logic [KEY_BITS-1:0]   r_read_value, r_evicted_key;

    t_pick                 w_pick;
    logic                  w_accept;
    logic                  w_last_rd;
    logic                  w_occ_lt_cap;
    logic                  w_put_ok, w_fill, w_evict, w_promo;
    logic [IW-1:0]         w_tgt;
    logic [COUNT_BITS-1:0] w_bumped;

    logic                  w_ent_we;
    logic [COUNT_BITS-1:0] w_cnt_d;
    logic                  w_rank_we;
    logic [RW-1:0]         w_rank_d;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_last_rd = r_rdv && (r_rdidx == LAST_IDX);

    lfu_pick #(
        .COUNT_BITS (COUNT_BITS),
        .RANK_BITS  (RW)
    ) u_pick (
        .i_valid       (r_valid[r_rdidx]),
        .i_key         (r_rd_key),
        .i_ref_key     (r_key),
        .i_cnt         (r_rd_cnt),
        .i_rank        (r_rd_rank),
        .i_have_match  (r_have_match),
        .i_have_free   (r_have_free),
        .i_have_victim (r_have_vic),
        .i_best_cnt    (r_v_cnt),
        .i_best_rank   (r_v_rank),
        .o_pick        (w_pick)
    );

    // request decision
    always_comb begin
        w_occ_lt_cap = (CMPW'(r_occ) < CMPW'(r_cap)) && (CMPW'(r_occ) < CMPW'(ENTRIES));
        w_put_ok     = r_mode && (r_cap != '0);
        w_fill       = w_put_ok && !r_have_match && w_occ_lt_cap;
        w_evict      = w_put_ok && !r_have_match && !w_occ_lt_cap && r_have_vic;
        w_promo      = (r_have_match && (!r_mode || w_put_ok)) || w_fill || w_evict;
        w_tgt        = r_have_match ? r_m_idx : (w_fill ? r_f_idx : r_v_idx);
        w_bumped     = (r_m_cnt == '1) ? r_m_cnt : r_m_cnt + COUNT_BITS'(1);
        w_ent_we     = (r_state == S_DECIDE) && w_promo;
        w_cnt_d      = r_have_match ? w_bumped : COUNT_BITS'(NEW_COUNT);
    end

    // recency sweep
    always_comb begin
        w_rank_we = 1'b0;
        w_rank_d  = r_rd_rank + RW'(1);
        if (r_state == S_PROMO && r_rdv) begin
            if (r_rdidx == r_tgt) begin
                w_rank_we = 1'b1;
                w_rank_d  = '0;
            end else if (r_valid[r_rdidx] && (r_lim_all || r_rd_rank < r_lim)) begin
                w_rank_we = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_SCAN;
            S_SCAN:   if (w_last_rd) n_state = S_DECIDE;
            S_DECIDE: n_state = w_promo ? S_PROMO : S_IDLE;
            S_PROMO:  if (w_last_rd) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            mem_key[w_tgt] <= r_key;
            mem_cnt[w_tgt] <= w_cnt_d;
        end
        if (w_ent_we && r_mode) begin
            mem_val[w_tgt] <= r_value;
        end
        if (w_rank_we) begin
            mem_rank[r_rdidx] <= w_rank_d;
        end
        r_rd_key  <= mem_key[r_idx];
        r_rd_val  <= mem_val[r_idx];
        r_rd_cnt  <= mem_cnt[r_idx];
        r_rd_rank <= mem_rank[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CAP_BITS'(CAP_RESET);
            r_occ   <= '0;
            r_valid <= '0;
            r_issue <= 1'b0;
            r_rdv   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == S_DECIDE) && !w_promo) ||
                       ((r_state == S_PROMO) && w_last_rd);
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (r_issue) begin
                r_rdv   <= 1'b1;
                r_rdidx <= r_idx;
                if (r_idx == LAST_IDX) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end else begin
                r_rdv <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode       <= i_mode;
                        r_key        <= i_key;
                        r_value      <= i_value;
                        r_idx        <= '0;
                        r_issue      <= 1'b1;
                        r_have_match <= 1'b0;
                        r_have_free  <= 1'b0;
                        r_have_vic   <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (r_rdv) begin
                        if (w_pick.take_match) begin
                            r_have_match <= 1'b1;
                            r_m_idx      <= r_rdidx;
                            r_m_cnt      <= r_rd_cnt;
                            r_m_rank     <= r_rd_rank;
                            r_m_val      <= r_rd_val;
                        end
                        if (w_pick.take_free) begin
                            r_have_free <= 1'b1;
                            r_f_idx     <= r_rdidx;
                        end
                        if (w_pick.take_victim) begin
                            r_have_vic <= 1'b1;
                            r_v_idx    <= r_rdidx;
                            r_v_cnt    <= r_rd_cnt;
                            r_v_rank   <= r_rd_rank;
                            r_v_key    <= r_rd_key;
                        end
                    end
                end
                S_DECIDE: begin
                    r_tgt         <= w_tgt;
                    r_lim         <= r_have_match ? r_m_rank : r_v_rank;
                    r_lim_all     <= w_fill;
                    r_idx         <= '0;
                    r_issue       <= w_promo;
                    r_hit         <= r_have_match;
                    r_read_value  <= (r_have_match && !r_mode) ? r_m_val : MISS_VALUE;
                    r_evicted     <= w_evict;
                    r_evicted_key <= w_evict ? r_v_key : NO_KEY;
                    if (w_fill) begin
                        r_valid[r_f_idx] <= 1'b1;
                        r_occ            <= r_occ + OW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_occ) <= CMPW'(ENTRIES))
        else $error("occupancy beyond table size");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_evicted) |-> !o_hit)
        else $error("eviction on a hit");

    a_occ_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != $past(r_occ)) |-> $past(r_state == S_DECIDE))
        else $error("occupancy changed outside decide");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN && r_issue))
        else $error("accepted request did not start a scan");

endmodule
